>>> sv/apc_pkg.sv
// shared constants for the absolute pearson correlation core
// no dependencies
package apc_pkg;
	localparam int MaxLen = 4096;
	localparam int CntW   = 13;
	localparam int SmpW   = 16;
	localparam int QW     = 16;
	localparam int SxW    = 28;
	localparam int SxxW   = 43;
	localparam int VarW   = 56;
	localparam int WideW  = 144;
	localparam int LenW   = 6;
endpackage

>>> sv/apc_pair_if.sv
// sample pair request channel
// depends on apc_pkg
interface apc_pair_if;
	logic                          valid;
	logic                          ready;
	logic signed [apc_pkg::SmpW-1:0] sample_x;
	logic signed [apc_pkg::SmpW-1:0] sample_y;
	logic                          last_pair;
	modport source (output valid, sample_x, sample_y, last_pair, input ready);
	modport sink (input valid, sample_x, sample_y, last_pair, output ready);
endinterface

>>> sv/apc_res_if.sv
// correlation result request channel
// depends on apc_pkg
interface apc_res_if;
	logic                      valid;
	logic                      ready;
	logic [apc_pkg::QW-1:0]    abs_corr;
	logic                      degenerate;
	logic                      overflowed;
	logic [apc_pkg::CntW-1:0]  pair_count;
	modport source (output valid, abs_corr, degenerate, overflowed, pair_count, input ready);
	modport sink (input valid, abs_corr, degenerate, overflowed, pair_count, output ready);
endinterface

>>> sv/abs_pearson_correlation_core.sv
// absolute pearson correlation core, top level
// depends on apc_pkg, apc_pair_if, apc_res_if
//
// pair_in takes one (sample_x, sample_y, last_pair) request at a time. the
// pair is folded exactly into n, sum x, sum y, sum xy, sum xx and sum yy.
// all sums and products go through one shared 144-bit adder: products are made
// by a shift-add sequencer, one multiplier bit per cycle.
// a pair that is not last runs two sum adds and three 16-bit products, each
// followed by one accumulate; ready is low meanwhile.
// pairs beyond 4096 are dropped and mark the result overflowed.
// a last pair then runs the finish: six products for c, vx and vy, two
// 56-bit products for vx*vy and c*c, then a 16-step bit-by-bit search
// (states S_S0, S_S1 and, for a set bit, S_S2 in each step); the last two
// products and the search are skipped when a series is constant.
// the result sits in an output register on res_out; if the receiver stalls
// the core holds in its final state until the register is free.
// reset clears all sums, the counter and the result valid at once.
// zero variance gives abs_corr 0 with degenerate set.
module abs_pearson_correlation_core (
	input  logic       clk,
	input  logic       arst_n,
	apc_pair_if.sink   pair_in,
	apc_res_if.source  res_out
);
	localparam int W = apc_pkg::WideW;

	typedef enum logic [4:0] {
		S_IDLE, S_AX, S_AY, S_AXY, S_AXX, S_AYY, S_MUL,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9,
		S_S0, S_S1, S_S2, S_DONE
	} state_t;

	function automatic logic [W-1:0] ext16(input logic [apc_pkg::SmpW-1:0] v);
		return {{(W-apc_pkg::SmpW){v[apc_pkg::SmpW-1]}}, v};
	endfunction
	function automatic logic [W-1:0] ext28(input logic [apc_pkg::SxW-1:0] v);
		return {{(W-apc_pkg::SxW){v[apc_pkg::SxW-1]}}, v};
	endfunction
	function automatic logic [W-1:0] ext43(input logic [apc_pkg::SxxW-1:0] v);
		return {{(W-apc_pkg::SxxW){v[apc_pkg::SxxW-1]}}, v};
	endfunction
	function automatic logic [W-1:0] ext56(input logic [apc_pkg::VarW-1:0] v);
		return {{(W-apc_pkg::VarW){v[apc_pkg::VarW-1]}}, v};
	endfunction

	state_t                          state_q, ret_q;
	logic [apc_pkg::SmpW-1:0]        x_q, y_q;
	logic                            last_q;
	logic [apc_pkg::CntW-1:0]        n_q;
	logic [apc_pkg::SxW-1:0]         sx_q, sy_q;
	logic [apc_pkg::SxxW-1:0]        sxy_q, sxx_q, syy_q;
	logic                            ovf_q;
	// shift-add multiplier
	logic [W-1:0]                    acc_q, mc_q;
	logic [apc_pkg::VarW-1:0]        mp_q;
	logic [apc_pkg::LenW-1:0]        cnt_q, len_q;
	// finish datapath
	logic [W-1:0]                    t_q, base_q, rhs_q, p_q, qs_q, bk_q;
	logic [apc_pkg::VarW-1:0]        c_q, vx_q, vy_q;
	logic [3:0]                      k_q;
	logic [apc_pkg::QW-1:0]          q_q;
	logic                            degen_q;
	// result register
	logic                            out_valid_q;
	logic [apc_pkg::QW-1:0]          out_corr_q;
	logic                            out_degen_q, out_ovf_q;
	logic [apc_pkg::CntW-1:0]        out_cnt_q;

	logic [W-1:0] add_a, add_b, sum_w;
	logic         add_sub, mul_last;

	assign mul_last = (cnt_q == len_q - apc_pkg::LenW'(1));

	// the one shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_AX:  begin add_a = ext28(sx_q);  add_b = ext16(x_q); end
			S_AY:  begin add_a = ext28(sy_q);  add_b = ext16(y_q); end
			S_AXY: begin add_a = ext43(sxy_q); add_b = acc_q; end
			S_AXX: begin add_a = ext43(sxx_q); add_b = acc_q; end
			S_AYY: begin add_a = ext43(syy_q); add_b = acc_q; end
			// top multiplier bit carries negative weight
			S_MUL: begin add_a = acc_q; add_b = mc_q; add_sub = mul_last; end
			S_F2, S_F4, S_F6: begin add_a = t_q; add_b = acc_q; add_sub = 1'b1; end
			S_S0:  begin add_a = p_q;  add_b = qs_q; end
			S_S1:  begin add_a = t_q;  add_b = bk_q; end
			S_S2:  begin add_a = qs_q; add_b = bk_q << 1; end
			default: begin add_a = '0; add_b = '0; add_sub = 1'b0; end
		endcase
		sum_w = add_a + (add_sub ? ~add_b : add_b) + W'(add_sub);
	end

	assign pair_in.ready      = (state_q == S_IDLE);
	assign res_out.valid      = out_valid_q;
	assign res_out.abs_corr   = out_corr_q;
	assign res_out.degenerate = out_degen_q;
	assign res_out.overflowed = out_ovf_q;
	assign res_out.pair_count = out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;   ret_q <= S_IDLE;
			x_q <= '0; y_q <= '0; last_q <= 1'b0;
			n_q <= '0; sx_q <= '0; sy_q <= '0;
			sxy_q <= '0; sxx_q <= '0; syy_q <= '0; ovf_q <= 1'b0;
			acc_q <= '0; mc_q <= '0; mp_q <= '0; cnt_q <= '0; len_q <= '0;
			t_q <= '0; base_q <= '0; rhs_q <= '0; p_q <= '0; qs_q <= '0; bk_q <= '0;
			c_q <= '0; vx_q <= '0; vy_q <= '0; k_q <= '0; q_q <= '0; degen_q <= 1'b0;
			out_valid_q <= 1'b0; out_corr_q <= '0; out_degen_q <= 1'b0;
			out_ovf_q <= 1'b0; out_cnt_q <= '0;
		end else begin
			// the final state reloads the result register itself
			if (out_valid_q && res_out.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pair_in.valid) begin
						x_q    <= pair_in.sample_x;
						y_q    <= pair_in.sample_y;
						last_q <= pair_in.last_pair;
						if (n_q < apc_pkg::CntW'(apc_pkg::MaxLen)) begin
							state_q <= S_AX;
						end else begin
							// extra pair dropped
							ovf_q   <= 1'b1;
							state_q <= pair_in.last_pair ? S_F0 : S_IDLE;
						end
					end
				end
				S_AX: begin
					sx_q    <= sum_w[apc_pkg::SxW-1:0];
					state_q <= S_AY;
				end
				S_AY: begin
					sy_q  <= sum_w[apc_pkg::SxW-1:0];
					acc_q <= '0; mc_q <= ext16(x_q);
					mp_q  <= apc_pkg::VarW'(y_q); len_q <= apc_pkg::LenW'(16);
					cnt_q <= '0; ret_q <= S_AXY; state_q <= S_MUL;
				end
				S_AXY: begin
					sxy_q <= sum_w[apc_pkg::SxxW-1:0];
					acc_q <= '0; mc_q <= ext16(x_q);
					mp_q  <= apc_pkg::VarW'(x_q); len_q <= apc_pkg::LenW'(16);
					cnt_q <= '0; ret_q <= S_AXX; state_q <= S_MUL;
				end
				S_AXX: begin
					sxx_q <= sum_w[apc_pkg::SxxW-1:0];
					acc_q <= '0; mc_q <= ext16(y_q);
					mp_q  <= apc_pkg::VarW'(y_q); len_q <= apc_pkg::LenW'(16);
					cnt_q <= '0; ret_q <= S_AYY; state_q <= S_MUL;
				end
				S_AYY: begin
					syy_q   <= sum_w[apc_pkg::SxxW-1:0];
					n_q     <= n_q + 1'b1;
					state_q <= last_q ? S_F0 : S_IDLE;
				end
				S_MUL: begin
					if (mp_q[0])
						acc_q <= sum_w;
					mc_q  <= mc_q << 1;
					mp_q  <= mp_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (mul_last)
						state_q <= ret_q;
				end
				S_F0: begin
					acc_q <= '0; mc_q <= ext43(sxy_q);
					mp_q  <= apc_pkg::VarW'(n_q); len_q <= apc_pkg::LenW'(14);
					cnt_q <= '0; ret_q <= S_F1; state_q <= S_MUL;
				end
				S_F1: begin
					t_q   <= acc_q;
					acc_q <= '0; mc_q <= ext28(sx_q);
					mp_q  <= apc_pkg::VarW'(sy_q); len_q <= apc_pkg::LenW'(28);
					cnt_q <= '0; ret_q <= S_F2; state_q <= S_MUL;
				end
				S_F2: begin
					c_q   <= sum_w[apc_pkg::VarW-1:0];
					acc_q <= '0; mc_q <= ext43(sxx_q);
					mp_q  <= apc_pkg::VarW'(n_q); len_q <= apc_pkg::LenW'(14);
					cnt_q <= '0; ret_q <= S_F3; state_q <= S_MUL;
				end
				S_F3: begin
					t_q   <= acc_q;
					acc_q <= '0; mc_q <= ext28(sx_q);
					mp_q  <= apc_pkg::VarW'(sx_q); len_q <= apc_pkg::LenW'(28);
					cnt_q <= '0; ret_q <= S_F4; state_q <= S_MUL;
				end
				S_F4: begin
					vx_q  <= sum_w[apc_pkg::VarW-1:0];
					acc_q <= '0; mc_q <= ext43(syy_q);
					mp_q  <= apc_pkg::VarW'(n_q); len_q <= apc_pkg::LenW'(14);
					cnt_q <= '0; ret_q <= S_F5; state_q <= S_MUL;
				end
				S_F5: begin
					t_q   <= acc_q;
					acc_q <= '0; mc_q <= ext28(sy_q);
					mp_q  <= apc_pkg::VarW'(sy_q); len_q <= apc_pkg::LenW'(28);
					cnt_q <= '0; ret_q <= S_F6; state_q <= S_MUL;
				end
				S_F6: begin
					vy_q    <= sum_w[apc_pkg::VarW-1:0];
					state_q <= S_F7;
				end
				S_F7: begin
					if (vx_q == '0 || vy_q == '0) begin
						// constant series
						q_q     <= '0;
						degen_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						degen_q <= 1'b0;
						acc_q <= '0; mc_q <= ext56(vx_q);
						mp_q  <= vy_q; len_q <= apc_pkg::LenW'(apc_pkg::VarW);
						cnt_q <= '0; ret_q <= S_F8; state_q <= S_MUL;
					end
				end
				S_F8: begin
					base_q <= acc_q;
					acc_q <= '0; mc_q <= ext56(c_q);
					mp_q  <= c_q; len_q <= apc_pkg::LenW'(apc_pkg::VarW);
					cnt_q <= '0; ret_q <= S_F9; state_q <= S_MUL;
				end
				S_F9: begin
					// rhs = c^2 * 2^30; search keeps q^2*base and q*base shifted
					rhs_q   <= acc_q << 30;
					bk_q    <= base_q << 30;
					p_q     <= '0;
					qs_q    <= '0;
					q_q     <= '0;
					k_q     <= 4'd15;
					state_q <= S_S0;
				end
				S_S0: begin
					t_q     <= sum_w;
					state_q <= S_S1;
				end
				S_S1: begin
					if (sum_w <= rhs_q) begin
						p_q     <= sum_w;
						q_q[k_q] <= 1'b1;
						state_q <= S_S2;
					end else begin
						qs_q    <= qs_q >> 1;
						bk_q    <= bk_q >> 2;
						k_q     <= k_q - 1'b1;
						state_q <= (k_q == 4'd0) ? S_DONE : S_S0;
					end
				end
				S_S2: begin
					qs_q    <= sum_w >> 1;
					bk_q    <= bk_q >> 2;
					k_q     <= k_q - 1'b1;
					state_q <= (k_q == 4'd0) ? S_DONE : S_S0;
				end
				S_DONE: begin
					if (!out_valid_q || res_out.ready) begin
						out_valid_q <= 1'b1;
						out_corr_q  <= q_q;
						out_degen_q <= degen_q;
						out_ovf_q   <= ovf_q;
						out_cnt_q   <= n_q;
						n_q   <= '0; sx_q <= '0; sy_q <= '0;
						sxy_q <= '0; sxx_q <= '0; syy_q <= '0; ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/apc_checker.sv
// port-level checks for the absolute pearson correlation core
// depends on apc_pkg and abs_pearson_correlation_core; bound to the core below
module apc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [apc_pkg::QW-1:0]     abs_corr,
	input logic                       degenerate
);
	// a waiting result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an idle core stays ready until a request arrives
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("ready dropped without a request");

	// a new result only comes out of the finish sequence
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

	// degenerate results carry zero
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> abs_corr == '0)
		else $error("degenerate result not zero");
endmodule

bind abs_pearson_correlation_core apc_checker u_apc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pair_in.valid),
	.in_ready   (pair_in.ready),
	.out_valid  (res_out.valid),
	.out_ready  (res_out.ready),
	.abs_corr   (res_out.abs_corr),
	.degenerate (res_out.degenerate)
);
